[sv/sha1_byte_stream_hasher_macros.svh]
// ----------------------------------------------------------------------------
// SHA-1 hasher assertion macros
// Shared assertion forms for the hasher top level.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sha1_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 package
// Commands, initial values and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package sha1_pkg;
    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_DIGEST  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;   // 448 bits

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = 32'h5A827999;
        else if (r < 7'd40) k = 32'h6ED9EBA1;
        else if (r < 7'd60) k = 32'h8F1BBCDC;
        else                k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)                    f = (b & c) | (~b & d);
        else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                              f = b ^ c ^ d;
        return f;
    endfunction
endpackage
`default_nettype wire

[sv/sha1_byte_stream_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-1 byte-stream hasher
// Absorbs message bytes, compresses full blocks, emits padded digests.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload
// in      | sink      | cmd, data_byte
// out     | source    | digest_word, word_index, last_word
//
// Absorb, restart, unused code: taken straight from idle; a byte that fills the block
// starts a compression (accept, load, rounds, fold through the one round unit).
// Digest: accept, byte-wide copy/pad, one compression, then five words; with 56
// or more bytes buffered, a second pad block and compression come first.
// Reset clears control and chaining state, not the byte buffers.
// Not ready while busy; an output stall holds the word and adds cycles.
`default_nettype none
module sha1_byte_stream_hasher
    import sha1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
`include "sha1_byte_stream_hasher_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_PAD_COPY, S_PAD_FILL, S_LOAD, S_ROUND, S_FOLD, S_EMIT
    } state_t;

    state_t       state_reg;
    logic [31:0]  h_reg [5];      // running chaining value
    logic [31:0]  t_reg [5];      // digest working chain
    logic [63:0]  bit_count_reg;
    logic [5:0]   fill_reg;
    logic [31:0]  buf_mem [16];   // message bytes, big-endian within a word
    logic [31:0]  pad_mem [16];   // padded copy for digests
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]   rnd_reg;
    logic         dig_reg;        // compressing for a digest
    logic         second_reg;     // a second pad block follows
    logic [6:0]   pos_reg;
    logic [2:0]   oidx_reg;
    logic [3:0]   ld_idx;
    logic [4:0]   fill_lane, pos_lane;
    logic [31:0]  wnew, tmp, wcur;

    assign ld_idx    = rnd_reg[3:0];
    // byte 0 of a word sits in bits 31:24
    assign fill_lane = {~fill_reg[1:0], 3'd0};
    assign pos_lane  = {~pos_reg[1:0], 3'd0};

    assign wnew = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                | {31'd0, w_reg[13][31] ^ w_reg[8][31] ^ w_reg[2][31] ^ w_reg[0][31]};
    assign wcur = (rnd_reg < 7'd16) ? w_reg[0] : wnew;
    assign tmp  = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                + e_reg + round_k(rnd_reg) + wcur;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_EMIT);
    assign digest_word = t_reg[oidx_reg];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == 3'd4);

    // byte memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && cmd == CMD_ABSORB)
            buf_mem[fill_reg[5:2]][fill_lane +: 8] <= data_byte;
        if (state_reg == S_PAD_COPY)
            pad_mem[pos_reg[5:2]] <= buf_mem[pos_reg[5:2]];
        if (state_reg == S_PAD_FILL)
        begin
            if (pos_reg[5:0] == fill_reg && !second_reg)
                pad_mem[pos_reg[5:2]][pos_lane +: 8] <= 8'h80;
            else if (pos_reg >= 7'(LEN_POS) && !(fill_reg >= 6'd56 && !second_reg))
                pad_mem[pos_reg[5:2]][pos_lane +: 8]
                    <= bit_count_reg[8'd63 - {pos_reg[2:0], 3'd0} -: 8];
            else
                pad_mem[pos_reg[5:2]][pos_lane +: 8] <= 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
            bit_count_reg <= '0;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            dig_reg       <= 1'b0;
            second_reg    <= 1'b0;
            pos_reg       <= '0;
            oidx_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        unique case (cmd)
                            CMD_ABSORB:
                            begin
                                bit_count_reg <= bit_count_reg + 64'd8;
                                fill_reg      <= fill_reg + 6'd1;
                                if (fill_reg == 6'd63)
                                begin
                                    dig_reg <= 1'b0;
                                    rnd_reg <= '0;
                                    for (int i = 0; i < 5; i++) t_reg[i] <= h_reg[i];
                                    state_reg <= S_LOAD;
                                end
                            end
                            CMD_DIGEST:
                            begin
                                for (int i = 0; i < 5; i++) t_reg[i] <= h_reg[i];
                                pos_reg    <= '0;
                                second_reg <= 1'b0;
                                dig_reg    <= 1'b1;
                                state_reg  <= S_PAD_COPY;
                            end
                            CMD_RESTART:
                            begin
                                h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT;
                                h_reg[2] <= H2_INIT; h_reg[3] <= H3_INIT;
                                h_reg[4] <= H4_INIT;
                                bit_count_reg <= '0;
                                fill_reg      <= '0;
                            end
                            default: ;
                        endcase
                    end
                S_PAD_COPY:
                    if (pos_reg[5:0] == fill_reg)
                        state_reg <= S_PAD_FILL;
                    else
                        pos_reg <= pos_reg + 7'd1;
                S_PAD_FILL:
                    if (pos_reg == 7'd63)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= S_LOAD;
                    end
                    else
                        pos_reg <= pos_reg + 7'd1;
                S_LOAD:
                begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= dig_reg ? pad_mem[ld_idx] : buf_mem[ld_idx];
                    if (rnd_reg == 7'd15)
                    begin
                        rnd_reg <= '0;
                        a_reg <= t_reg[0]; b_reg <= t_reg[1]; c_reg <= t_reg[2];
                        d_reg <= t_reg[3]; e_reg <= t_reg[4];
                        state_reg <= S_ROUND;
                    end
                    else
                        rnd_reg <= rnd_reg + 7'd1;
                end
                S_ROUND:
                begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= wcur;
                    a_reg <= tmp; b_reg <= a_reg;
                    c_reg <= {b_reg[1:0], b_reg[31:2]};
                    d_reg <= c_reg; e_reg <= d_reg;
                    if (rnd_reg == 7'd79) state_reg <= S_FOLD;
                    rnd_reg <= rnd_reg + 7'd1;
                end
                S_FOLD:
                begin
                    t_reg[0] <= t_reg[0] + a_reg; t_reg[1] <= t_reg[1] + b_reg;
                    t_reg[2] <= t_reg[2] + c_reg; t_reg[3] <= t_reg[3] + d_reg;
                    t_reg[4] <= t_reg[4] + e_reg;
                    rnd_reg <= '0;
                    if (!dig_reg)
                    begin
                        h_reg[0] <= t_reg[0] + a_reg; h_reg[1] <= t_reg[1] + b_reg;
                        h_reg[2] <= t_reg[2] + c_reg; h_reg[3] <= t_reg[3] + d_reg;
                        h_reg[4] <= t_reg[4] + e_reg;
                        state_reg <= S_IDLE;
                    end
                    else if (fill_reg >= 6'd56 && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        pos_reg    <= '0;
                        state_reg  <= S_PAD_FILL;
                    end
                    else
                    begin
                        oidx_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd4) state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SHA_ASSERT_IMPL(a_emit_idx, clk, rst_n, out_valid, oidx_reg <= 3'd4,
        "word index out of range")
    `SHA_ASSERT_NEXT(a_last_done, clk, rst_n, out_valid && out_ready && last_word,
        in_ready, "not idle after last word")
    `SHA_ASSERT_IMPL(a_busy, clk, rst_n, out_valid, !in_ready,
        "ready while emitting")
endmodule
`default_nettype wire

[tb/sha1_byte_stream_hasher_test.sv]
// ----------------------------------------------------------------------------
// SHA-1 byte-stream hasher testbench
// Streams absorb, digest, restart and unused-code words into the hasher, predicts each
// digest with a local SHA-1 model and compares every output word in order.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_test
    import sha1_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_ABSORB;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // idle percentages for the sender and the receiver
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;

    // predicted hasher state
    logic [31:0] chain_h[5];
    logic [63:0] msg_bits;
    logic [7:0]  blk_bytes[64];
    int unsigned blk_fill;

    digest_out_t pending_words[$];

    always #1 clk = ~clk;

    sha1_byte_stream_hasher DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .data_byte(data_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one 80-round SHA-1 compression of a 64-byte block into h
    task automatic sha1_compress(inout logic [31:0] h[5], input logic [7:0] b[64]);
        logic [31:0] w[80];
        logic [31:0] a, bb, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (bb & c) | (~bb & d); k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = bb ^ c ^ d; k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
            end
            else
            begin
                f = bb ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(bb, 30); bb = a; a = t;
        end
        h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
    endtask

    task automatic restart_hash();
        chain_h[0] = H0_INIT; chain_h[1] = H1_INIT; chain_h[2] = H2_INIT;
        chain_h[3] = H3_INIT; chain_h[4] = H4_INIT;
        msg_bits = '0;
        blk_fill = 0;
        foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
    endtask

    // update the predicted state for one accepted word, queue any digest
    task automatic predict_word(input logic [1:0] c, input logic [7:0] db);
        logic [31:0] h[5];
        logic [7:0]  b[64];
        int unsigned p;
        digest_out_t o;
        unique case (c)
            CMD_ABSORB:
            begin
                blk_bytes[blk_fill] = db;
                msg_bits += 64'd8;
                blk_fill = (blk_fill + 1) % 64;
                if (blk_fill == 0) sha1_compress(chain_h, blk_bytes);
            end
            CMD_RESTART: restart_hash();
            CMD_DIGEST:
            begin
                h = chain_h;
                b = blk_bytes;
                p = blk_fill;
                b[p] = 8'h80;
                p++;
                // no room for the length: pad out and spill to a second block
                if (p > 56)
                begin
                    for (int i = p; i < 64; i++) b[i] = 8'h00;
                    sha1_compress(h, b);
                    p = 0;
                end
                for (int i = p; i < 56; i++) b[i] = 8'h00;
                for (int i = 0; i < 8; i++) b[56+i] = msg_bits[63-8*i -: 8];
                sha1_compress(h, b);
                for (int i = 0; i < 5; i++)
                begin
                    o.digest_word = h[i];
                    o.word_index = 3'(i);
                    o.last_word = (i == 4);
                    pending_words.push_back(o);
                end
            end
            default: ;  // unused code is ignored
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // send one word, holding valid until accepted
    task automatic send_word(input logic [1:0] c, input logic [7:0] db);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        data_byte <= db;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(c, db);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // receiver: random stalls, checks each accepted word against the queue
    always @(posedge clk)
    begin
        digest_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", digest_word, 32'd0);
            else
            begin
                e = pending_words.pop_front();
                if (digest_word !== e.digest_word)
                    report_mismatch("digest_word", digest_word, e.digest_word);
                if (word_index !== e.word_index)
                    report_mismatch("word_index", 32'(word_index), 32'(e.word_index));
                if (last_word !== e.last_word)
                    report_mismatch("last_word", 32'(last_word), 32'(e.last_word));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_known_vectors();
        // empty message, "abc", digest repeated without change, an unused code, more bytes, restart
        send_word(CMD_DIGEST, 8'h00);
        send_word(CMD_ABSORB, 8'h61);
        send_word(CMD_ABSORB, 8'h62);
        send_word(CMD_ABSORB, 8'h63);
        send_word(CMD_DIGEST, 8'hFF);
        send_word(CMD_DIGEST, 8'h00);
        send_word(CMD_UNUSED, 8'hA5);
        send_word(CMD_ABSORB, 8'hFF);
        send_word(CMD_ABSORB, 8'h00);
        send_word(CMD_DIGEST, 8'h00);
        send_word(CMD_RESTART, 8'h5A);
        send_word(CMD_DIGEST, 8'h00);
    endtask

    // fill to each padding boundary: 55 fits, 56 spills, 63 spills, 64 full
    task automatic test_pad_boundaries();
        int lens[4] = '{55, 56, 63, 64};
        foreach (lens[j])
        begin
            send_word(CMD_RESTART, 8'h00);
            for (int i = 0; i < lens[j]; i++) send_word(CMD_ABSORB, 8'($urandom));
            send_word(CMD_DIGEST, 8'h00);
        end
    endtask

    // wait for all digests before continuing
    task automatic test_quiet_pause();
        send_word(CMD_ABSORB, 8'h3C);
        send_word(CMD_DIGEST, 8'h00);
        drain();
        send_word(CMD_DIGEST, 8'h00);
    endtask

    // mostly message bytes with occasional digests, rare restarts and noise
    task automatic test_random_stream(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 80)      send_word(CMD_ABSORB, 8'($urandom));
            else if (r < 93) send_word(CMD_DIGEST, 8'($urandom));
            else if (r < 97) send_word(CMD_RESTART, 8'($urandom));
            else             send_word(CMD_UNUSED, 8'($urandom));
        end
    endtask

    initial
    begin
        restart_hash();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_vectors();
        test_pad_boundaries();
        test_quiet_pause();
        // idling phases: none, sender, receiver, both
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random_stream(12);
        send_idle_pct = 58; recv_stall_pct = 0;  test_random_stream(12);
        send_idle_pct = 0;  recv_stall_pct = 58; test_random_stream(12);
        send_idle_pct = 29; recv_stall_pct = 29; test_random_stream(12);
        drain();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end
endmodule
